>>> rtl/core/sk256_pkg.sv
package sk256_pkg;

  localparam int unsigned STATE_WORDS = 4;

  localparam logic [63:0] IV0 = 64'hFC9DA860D048B449;
  localparam logic [63:0] IV1 = 64'h2FCA66479FA7D833;
  localparam logic [63:0] IV2 = 64'hB33BC3896656840F;
  localparam logic [63:0] IV3 = 64'h6A54E920FDE8DA69;
  localparam logic [63:0] KEY_PARITY = 64'h1BD11BDAA9FC1A22;

  localparam logic [7:0] TAG_MSG   = 8'h30;
  localparam logic [7:0] TAG_FINAL = 8'hb0;
  localparam logic [7:0] TAG_OUT   = 8'hff;
  localparam logic [7:0] TAG_FIRST = 8'h40;

  localparam int unsigned QUEUE_DEPTH = 2;

  // one classified item between front and back
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } item_t;

  // rotation pair for a round, indexed by round mod 8
  function automatic logic [5:0] rot_a(input logic [2:0] r);
    logic [5:0] v;
    case (r)
      3'd0: v = 6'd14;
      3'd1: v = 6'd52;
      3'd2: v = 6'd23;
      3'd3: v = 6'd5;
      3'd4: v = 6'd25;
      3'd5: v = 6'd46;
      3'd6: v = 6'd58;
      default: v = 6'd32;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] rot_b(input logic [2:0] r);
    logic [5:0] v;
    case (r)
      3'd0: v = 6'd16;
      3'd1: v = 6'd57;
      3'd2: v = 6'd40;
      3'd3: v = 6'd37;
      3'd4: v = 6'd33;
      3'd5: v = 6'd12;
      3'd6: v = 6'd22;
      default: v = 6'd32;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rotl(input logic [63:0] v, input logic [5:0] r);
    return (v << r) | (v >> (7'd64 - {1'b0, r}));
  endfunction

  // small residues by repeated compare and subtract
  function automatic logic [2:0] mod5(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    for (int i = 0; i < 6; i++) begin
      if (r >= 5'd5) r = r - 5'd5;
    end
    return r[2:0];
  endfunction

  function automatic logic [1:0] mod3(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    for (int i = 0; i < 10; i++) begin
      if (r >= 5'd3) r = r - 5'd3;
    end
    return r[1:0];
  endfunction

endpackage

>>> rtl/core/sk256_front.sv
module sk256_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         data_word,
  input  logic [3:0]          byte_count,
  input  logic                last,
  output logic                q_valid,
  input  logic                q_ready,
  output sk256_pkg::item_t    q_item
);

  sk256_pkg::item_t mem [sk256_pkg::QUEUE_DEPTH];
  logic             wptr;
  logic             rptr;
  logic [1:0]       level;
  logic             push;
  logic             pop;
  sk256_pkg::item_t item_in;

  // clamp the byte count and mask bytes beyond it
  always_comb begin
    item_in.count = (byte_count > 4'd8) ? 4'd8 : byte_count;
    item_in.data  = data_word;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) >= item_in.count) item_in.data[8*i +: 8] = 8'h00;
    end
    item_in.last = last;
  end

  assign in_ready = (level != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (level != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      level <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      level <= level + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/core/sk256_round.sv
module sk256_round (
  input  logic [63:0] x_in  [4],
  input  logic [63:0] k_in  [5],
  input  logic [63:0] t_in  [3],
  input  logic [6:0]  rnd,
  input  logic        inject,
  output logic [63:0] x_out [4]
);

  logic [4:0]  s;
  logic [63:0] y [4];
  logic [63:0] a0, a1, a2, a3;

  assign s = rnd[6:2];

  // add subkey when inject is set, then one mix round with permute
  always_comb begin
    y = x_in;
    if (inject) begin
      y[0] = x_in[0] + k_in[sk256_pkg::mod5(s)];
      y[1] = x_in[1] + k_in[sk256_pkg::mod5(s + 5'd1)] + t_in[sk256_pkg::mod3(s)];
      y[2] = x_in[2] + k_in[sk256_pkg::mod5(s + 5'd2)] + t_in[sk256_pkg::mod3(s + 5'd1)];
      y[3] = x_in[3] + k_in[sk256_pkg::mod5(s + 5'd3)] + {59'd0, s};
    end
    a0 = y[0] + y[1];
    a1 = sk256_pkg::rotl(y[1], sk256_pkg::rot_a(rnd[2:0])) ^ a0;
    a2 = y[2] + y[3];
    a3 = sk256_pkg::rotl(y[3], sk256_pkg::rot_b(rnd[2:0])) ^ a2;
    x_out[0] = a0;
    x_out[1] = a3;
    x_out[2] = a2;
    x_out[3] = a1;
  end

endmodule

>>> rtl/core/sk256_back.sv
module sk256_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [5:0]          digest_bytes,
  input  logic                q_valid,
  output logic                q_ready,
  input  sk256_pkg::item_t    q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         digest_word,
  output logic [3:0]          word_bytes,
  output logic                last_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_BYTE, S_COMP, S_EMIT
  } state_t;

  state_t      state;
  logic [63:0] cv   [sk256_pkg::STATE_WORDS];
  logic [63:0] buff [sk256_pkg::STATE_WORDS];
  logic [63:0] x    [4];
  logic [63:0] k    [5];
  logic [63:0] t    [3];
  logic [63:0] x_next [4];
  logic [5:0]  fill;
  logic [63:0] blocks;
  sk256_pkg::item_t cur;
  logic [3:0]  idx;
  logic [6:0]  rnd;
  logic        fin_phase;
  logic        out_phase;
  logic        pend_final;
  logic [5:0]  want;
  logic [5:0]  left;
  logic [63:0] emit_word;

  sk256_round u_round (
    .x_in   (x),
    .k_in   (k),
    .t_in   (t),
    .rnd    (rnd),
    .inject (rnd[1:0] == 2'd0),
    .x_out  (x_next)
  );

  assign want = (digest_bytes == 6'd0) ? 6'd1 :
                (digest_bytes > 6'd32) ? 6'd32 : digest_bytes;
  assign q_ready = (state == S_IDLE);

  // mask digest bytes beyond the remaining length
  always_comb begin
    emit_word = cv[idx[1:0]];
    for (int i = 0; i < 8; i++) begin
      if (6'(i) >= left) emit_word[8*i +: 8] = 8'h00;
    end
  end

  // load tweak and key for a new compression
  task automatic start_comp(input logic [7:0] tg, input logic [5:0] len,
                            input logic [63:0] cnt);
    logic [63:0] l;
    logic [63:0] a;
    logic        c;
    logic [7:0]  g;
    l = cnt << 5;
    a = l + {58'd0, len};
    c = (a < l);
    g = (cnt == 64'd0) ? (tg | sk256_pkg::TAG_FIRST) : tg;
    t[0] <= a;
    t[1] <= ((cnt >> 59) + {63'd0, c}) | {g, 56'd0};
    t[2] <= a ^ (((cnt >> 59) + {63'd0, c}) | {g, 56'd0});
    k[0] <= cv[0]; k[1] <= cv[1]; k[2] <= cv[2]; k[3] <= cv[3];
    k[4] <= sk256_pkg::KEY_PARITY ^ cv[0] ^ cv[1] ^ cv[2] ^ cv[3];
    x    <= buff;
    rnd  <= 7'd0;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      cv[0] <= sk256_pkg::IV0; cv[1] <= sk256_pkg::IV1;
      cv[2] <= sk256_pkg::IV2; cv[3] <= sk256_pkg::IV3;
      buff[0] <= '0; buff[1] <= '0; buff[2] <= '0; buff[3] <= '0;
      fill       <= '0;
      blocks     <= '0;
      fin_phase  <= 1'b0;
      out_phase  <= 1'b0;
      pend_final <= 1'b0;
      idx        <= '0;
      rnd        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            idx   <= 4'd0;
            state <= S_BYTE;
          end
        end
        // append one byte a cycle; flush a held full block first
        S_BYTE: begin
          if (idx < cur.count) begin
            if (fill == 6'd32) begin
              start_comp(sk256_pkg::TAG_MSG, 6'd32, blocks);
              fin_phase <= 1'b0;
              out_phase <= 1'b0;
              state     <= S_COMP;
            end else begin
              buff[fill[4:3]][8*fill[2:0] +: 8] <= cur.data[8*idx[2:0] +: 8];
              fill <= fill + 6'd1;
              idx  <= idx + 4'd1;
            end
          end else if (cur.last) begin
            start_comp(sk256_pkg::TAG_FINAL, fill, blocks);
            fin_phase <= 1'b1;
            out_phase <= 1'b0;
            state     <= S_COMP;
          end else begin
            state <= S_IDLE;
          end
        end
        S_COMP: begin
          if (rnd == 7'd72) begin
            // final subkey (s = 18) and feed-forward
            cv[0] <= (x[0] + k[3]) ^ buff[0];
            cv[1] <= (x[1] + k[4] + t[0]) ^ buff[1];
            cv[2] <= (x[2] + k[0] + t[1]) ^ buff[2];
            cv[3] <= (x[3] + k[1] + 64'd18) ^ buff[3];
            buff[0] <= '0; buff[1] <= '0; buff[2] <= '0; buff[3] <= '0;
            if (out_phase) begin
              left       <= want;
              idx        <= 4'd0;
              pend_final <= 1'b1;
              state      <= S_EMIT;
            end else if (fin_phase) begin
              blocks     <= '0;
              pend_final <= 1'b1;
              state      <= S_COMP;
              out_phase  <= 1'b1;
              fin_phase  <= 1'b0;
              rnd        <= 7'd73;
            end else begin
              blocks <= blocks + 64'd1;
              fill   <= 6'd0;
              state  <= S_BYTE;
            end
          end else if (rnd == 7'd73) begin
            start_comp(sk256_pkg::TAG_OUT, 6'd8, 64'd0);
          end else begin
            x   <= x_next;
            rnd <= rnd + 7'd1;
          end
        end
        // present digest words one by one
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            if (pend_final) begin
              digest_word <= emit_word;
              word_bytes  <= (left > 6'd8) ? 4'd8 : left[3:0];
              last_word   <= (left <= 6'd8);
              out_valid   <= 1'b1;
              idx         <= idx + 4'd1;
              if (left <= 6'd8) pend_final <= 1'b0;
              else left <= left - 6'd8;
            end else begin
              out_valid <= 1'b0;
              cv[0] <= sk256_pkg::IV0; cv[1] <= sk256_pkg::IV1;
              cv[2] <= sk256_pkg::IV2; cv[3] <= sk256_pkg::IV3;
              fill   <= '0;
              blocks <= '0;
              state  <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/skein256_hash_engine.sv
// channel   direction  handshake              payload
// in        to block   in_valid / in_ready    data_word, byte_count, last
// out       from block out_valid / out_ready  digest_word, word_bytes, last_word
// cfg       to block   cfg_we                 cfg_data (digest_bytes)
// Bytes of an item are appended one by one, and each 32-byte block is compressed
// by the single Threefish round unit (load, 72 rounds, feed-forward).
// A last item adds two compressions, then emits the digest words and clears.
// Reset is synchronous and restores the IV and a digest length of 32.
// A two-entry queue lets input be taken while the back end is busy or stalled.
module skein256_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_word,
  output logic [3:0]  word_bytes,
  output logic        last_word
);

  logic             q_valid;
  logic             q_ready;
  sk256_pkg::item_t q_item;
  logic [5:0]       digest_bytes;

  // hold the digest length register
  always_ff @(posedge clk) begin
    if (rst) digest_bytes <= 6'd32;
    else if (cfg_we) digest_bytes <= cfg_data;
  end

  sk256_front u_front (
    .clk, .rst, .in_valid, .in_ready, .data_word, .byte_count, .last,
    .q_valid, .q_ready, .q_item
  );

  sk256_back u_back (
    .clk, .rst, .digest_bytes, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .digest_word, .word_bytes, .last_word
  );

endmodule

>>> rtl/core/sk256_checker.sv
module sk256_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] word_bytes,
  input logic       last_word,
  input logic [63:0] digest_word
);

  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (word_bytes != 4'd0 && word_bytes <= 4'd8)) else $error("bad count");

  a_short_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && word_bytes != 4'd8) |-> last_word) else $error("short not last");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(digest_word))) else $error("drop");

endmodule

bind skein256_hash_engine sk256_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .word_bytes, .last_word, .digest_word
);

>>> dv/tb_skein256_hash_engine.sv
`timescale 1ns / 100ps

module tb_skein256_hash_engine;

  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned RANDOM_ITEMS = 400;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        tail;
  } digest_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [5:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] digest_word;
  logic [3:0]  word_bytes;
  logic        last_word;

  // predictor state
  logic [63:0] cv_words [4];
  logic [63:0] msg_buf [4];
  int unsigned fill_cnt;
  logic [63:0] blk_cnt;
  logic [5:0]  digest_len;

  digest_t     digest_q [$];
  int unsigned err_count;
  int unsigned items_sent;
  int unsigned words_checked;
  int unsigned msgs_sent;
  longint unsigned cycle_cnt;
  int unsigned sink_hold;
  bit          no_gaps;

  skein256_hash_engine i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_word   (data_word),
    .byte_count  (byte_count),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_bytes  (word_bytes),
    .last_word   (last_word)
  );

  // clock and watchdog
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_skein256_hash_engine: errors");
      $finish;
    end
  end

  // restore the chaining context to the IV
  function automatic void clear_context();
    cv_words[0] = sk256_pkg::IV0;
    cv_words[1] = sk256_pkg::IV1;
    cv_words[2] = sk256_pkg::IV2;
    cv_words[3] = sk256_pkg::IV3;
    for (int i = 0; i < 4; i++) msg_buf[i] = '0;
    fill_cnt = 0;
    blk_cnt = '0;
  endfunction

  // one Threefish-256 compression of msg_buf into cv_words
  function automatic void threefish_block(input logic [7:0] tag, input int unsigned len);
    logic [63:0] kw [5];
    logic [63:0] tw [3];
    logic [63:0] x [4];
    logic [63:0] lo;
    logic [63:0] swap;
    logic [7:0]  tg;
    int unsigned ra [8];
    int unsigned rb [8];
    int unsigned s;
    ra = '{14, 52, 23, 5, 25, 46, 58, 32};
    rb = '{16, 57, 40, 37, 33, 12, 22, 32};
    tg = tag;
    if (blk_cnt == 0) tg = tg | sk256_pkg::TAG_FIRST;
    lo = blk_cnt << 5;
    tw[0] = lo + 64'(len);
    tw[1] = ((blk_cnt >> 59) + 64'(tw[0] < lo)) | {tg, 56'b0};
    tw[2] = tw[0] ^ tw[1];
    kw[4] = sk256_pkg::KEY_PARITY;
    for (int i = 0; i < 4; i++) begin
      kw[i] = cv_words[i];
      kw[4] = kw[4] ^ kw[i];
      x[i] = msg_buf[i];
    end
    // 72 rounds, key injection every fourth round and once after the last
    for (int d = 0; d <= 72; d++) begin
      if (d % 4 == 0) begin
        s = d / 4;
        x[0] = x[0] + kw[s % 5];
        x[1] = x[1] + kw[(s + 1) % 5] + tw[s % 3];
        x[2] = x[2] + kw[(s + 2) % 5] + tw[(s + 1) % 3];
        x[3] = x[3] + kw[(s + 3) % 5] + 64'(s);
      end
      if (d < 72) begin
        x[0] = x[0] + x[1];
        x[1] = ((x[1] << ra[d % 8]) | (x[1] >> (64 - ra[d % 8]))) ^ x[0];
        x[2] = x[2] + x[3];
        x[3] = ((x[3] << rb[d % 8]) | (x[3] >> (64 - rb[d % 8]))) ^ x[2];
        swap = x[1];
        x[1] = x[3];
        x[3] = swap;
      end
    end
    for (int i = 0; i < 4; i++) begin
      cv_words[i] = x[i] ^ msg_buf[i];
      msg_buf[i] = '0;
    end
    blk_cnt = blk_cnt + 1;
  endfunction

  // absorb one input item; on the end of a message queue the digest words
  function automatic void absorb_word(input logic [63:0] data, input logic [3:0] cnt,
                                     input logic fin);
    int unsigned n;
    int unsigned want;
    int unsigned nw;
    digest_t dw;
    n = (cnt > 8) ? 8 : cnt;
    for (int i = 0; i < n; i++) begin
      if (fill_cnt >= 32) begin
        threefish_block(sk256_pkg::TAG_MSG, 32);
        fill_cnt = 0;
      end
      msg_buf[fill_cnt / 8] = msg_buf[fill_cnt / 8] |
                              ({56'b0, data[8*i +: 8]} << (8 * (fill_cnt % 8)));
      fill_cnt++;
    end
    if (!fin) return;
    threefish_block(sk256_pkg::TAG_FINAL, fill_cnt);
    blk_cnt = '0;
    threefish_block(sk256_pkg::TAG_OUT, 8);
    want = digest_len;
    if (want == 0) want = 1;
    if (want > 32) want = 32;
    nw = (want + 7) / 8;
    for (int k = 0; k < nw; k++) begin
      dw.nbytes = 4'((want - 8 * k > 8) ? 8 : want - 8 * k);
      dw.word = cv_words[k];
      if (dw.nbytes < 8) dw.word = dw.word & ((64'd1 << (8 * dw.nbytes)) - 1);
      dw.tail = (k + 1 == nw);
      digest_q.push_back(dw);
    end
    clear_context();
  endfunction

  // offer one item after a random gap (none when no_gaps) and hold it until the transfer
  task automatic send_word(input logic [63:0] data, input logic [3:0] cnt, input logic fin);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_word = data;
    byte_count = cnt;
    last = fin;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    absorb_word(data, cnt, fin);
    items_sent++;
    if (fin) msgs_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // send a message of nbytes random bytes, junk above the valid bytes
  task automatic send_message(input int unsigned nbytes);
    int unsigned left;
    left = nbytes;
    while (left > 8) begin
      send_word(rand64(), 4'd8, 1'b0);
      left -= 8;
    end
    send_word(rand64(), 4'(left), 1'b1);
  endtask

  task automatic wait_drained();
    idle_input();
    wait (digest_q.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_digest_len(input logic [5:0] v);
    wait_drained();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    digest_len = v;
  endtask

  // check each digest transfer against the oldest expected word
  initial begin
    int unsigned gap;
    digest_t exp_w;
    out_ready = 1'b0;
    @(negedge clk);
    wait (!rst);
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_ready = 1'b0;
        repeat (sink_hold) @(negedge clk);
        sink_hold = 0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h", digest_word);
        err_count++;
      end else begin
        exp_w = digest_q.pop_front();
        words_checked++;
        if (digest_word !== exp_w.word) begin
          $error("digest_word expected %h actual %h", exp_w.word, digest_word);
          err_count++;
        end
        if (word_bytes !== exp_w.nbytes) begin
          $error("word_bytes expected %0d actual %0d", exp_w.nbytes, word_bytes);
          err_count++;
        end
        if (last_word !== exp_w.tail) begin
          $error("last_word expected %0d actual %0d", exp_w.tail, last_word);
          err_count++;
        end
      end
    end
  end

  // empty message, held-back full block, block boundary crossing
  task automatic test_block_edges();
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);
    send_message(32);
    send_message(33);
    send_word('0, 4'd8, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
  endtask

  // short counts mid-message, oversized counts, junk above the count
  task automatic test_odd_counts();
    send_word(rand64(), 4'd3, 1'b0);
    send_word(rand64(), 4'd0, 1'b0);
    send_word(rand64(), 4'd5, 1'b0);
    send_word(rand64(), 4'd15, 1'b0);
    send_word(rand64(), 4'd9, 1'b1);
    send_word(64'hFFFF_FFFF_FFFF_FF5A, 4'd1, 1'b1);
  endtask

  // digest lengths across and beyond the legal range
  task automatic test_digest_lengths();
    logic [5:0] lens [8];
    lens = '{6'd0, 6'd1, 6'd7, 6'd8, 6'd9, 6'd33, 6'd63, 6'd32};
    foreach (lens[i]) begin
      write_digest_len(lens[i]);
      send_message($urandom_range(0, 40));
    end
  endtask

  // stall the digest side long enough to back up the input
  task automatic test_backpressure();
    wait_drained();
    no_gaps = 1'b1;
    sink_hold = 600;
    for (int i = 0; i < 5; i++) send_word(rand64(), 4'd8, 1'b1);
    no_gaps = 1'b0;
    wait_drained();
  endtask

  // mostly well-formed messages, some with stray short or oversized counts
  task automatic test_random_messages();
    int unsigned start;
    int unsigned nbytes;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_word(rand64(), 4'($urandom_range(0, 15)), 1'b0);
      end else begin
        nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 160) : $urandom_range(0, 48);
        send_message(nbytes);
      end
      if ($urandom_range(0, 19) == 0) write_digest_len(6'($urandom_range(0, 63)));
    end
    no_gaps = 1'b0;
    send_word(rand64(), 4'($urandom_range(0, 15)), 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    data_word = '0;
    byte_count = '0;
    last = 1'b0;
    err_count = 0;
    items_sent = 0;
    words_checked = 0;
    msgs_sent = 0;
    cycle_cnt = 0;
    sink_hold = 0;
    no_gaps = 1'b0;
    clear_context();
    digest_len = 6'd32;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    test_block_edges();
    test_odd_counts();
    test_digest_lengths();
    test_backpressure();
    test_random_messages();

    wait_drained();
    $display("Covered %0d items in %0d messages, %0d digest words checked,",
             items_sent, msgs_sent, words_checked);
    $display("with digest lengths 0..63, empty and block-edge messages and backpressure.");
    if (err_count == 0) begin
      $display("tb_skein256_hash_engine: clean");
    end else begin
      $display("tb_skein256_hash_engine: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/sk256_pkg.sv
rtl/core/sk256_front.sv
rtl/core/sk256_round.sv
rtl/core/sk256_back.sv
rtl/core/skein256_hash_engine.sv
rtl/core/sk256_checker.sv
dv/tb_skein256_hash_engine.sv
